>>> design/x86ild_pkg.sv
// Package for the x86 instruction length decoder.
// Holds the request types, field codes and the one-byte opcode classification.
// No dependencies.
package x86ild_pkg;

	typedef enum logic [1:0] {
		K_NONE  = 2'd0,
		K_IMM8  = 2'd1,
		K_IMM32 = 2'd2,
		K_REL8  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_PLAIN   = 2'd0,
		ST_MODRM   = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_WORD  = 2'd1;
	localparam logic [1:0] SZ_DWORD = 2'd2;
	localparam logic [1:0] SZ_QWORD = 2'd3;

	localparam logic [7:0] OP_ESCAPE = 8'h0F;

	localparam logic [1:0] MOD_NODISP = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_REG    = 2'b11;
	localparam logic [2:0] RM_SIB     = 3'b100;
	localparam logic [2:0] RM_DISP32  = 3'b101;

	typedef struct packed {
		logic        listed;
		logic        modrm;
		logic [1:0]  size;
		kind_t       kind;
	} opclass_t;

	typedef struct packed {
		logic [7:0]  code_byte;
		logic [31:0] instr_address;
	} code_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         opcode;
		logic [3:0]         length;
		logic [7:0]         modrm_byte;
		logic               has_sib;
		logic [7:0]         sib_byte;
		logic signed [31:0] displacement;
		logic [31:0]        immediate;
		logic [1:0]         size_class;
		logic [31:0]        branch_target;
	} insn_t;

	function automatic opclass_t classify(input logic [7:0] op);
		opclass_t c;
		c = '0;
		if (op < 8'h40) begin
			if (op != OP_ESCAPE) begin
				c.listed = 1'b1;
				if (op[2:0] < 3'd4) begin
					c.modrm = 1'b1;
					c.size = op[0] ? SZ_DWORD : SZ_BYTE;
				end else if (op[2:0] == 3'd4) begin
					c.kind = K_IMM8;
				end else if (op[2:0] == 3'd5) begin
					c.kind = K_IMM32;
				end
			end
		end else if (op <= 8'h61) begin
			c.listed = 1'b1;
		end else if (op inside {[8'h70:8'h7F]}) begin
			c.listed = 1'b1;
			c.kind = K_REL8;
		end else begin
			case (op)
				8'h62: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_QWORD, kind: K_NONE};
				8'h63: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_WORD, kind: K_NONE};
				8'h68: c = '{listed: 1'b1, modrm: 1'b0, size: SZ_BYTE, kind: K_IMM32};
				8'h69: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_DWORD, kind: K_IMM32};
				8'h6A: c = '{listed: 1'b1, modrm: 1'b0, size: SZ_BYTE, kind: K_IMM8};
				8'h6B: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_DWORD, kind: K_IMM8};
				8'h80: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_BYTE, kind: K_IMM8};
				8'h81: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_DWORD, kind: K_IMM32};
				8'h83: c = '{listed: 1'b1, modrm: 1'b1, size: SZ_DWORD, kind: K_IMM8};
				8'h84, 8'h86:
					c = '{listed: 1'b1, modrm: 1'b1, size: SZ_BYTE, kind: K_NONE};
				8'h85, 8'h87:
					c = '{listed: 1'b1, modrm: 1'b1, size: SZ_DWORD, kind: K_NONE};
				8'h64, 8'h65, 8'h66, 8'h67, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h82:
					c = '{listed: 1'b1, modrm: 1'b0, size: SZ_BYTE, kind: K_NONE};
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] pos);
		logic [31:0] r;
		r = '0;
		case (pos)
			2'd0: r[7:0] = b;
			2'd1: r[15:8] = b;
			2'd2: r[23:16] = b;
			2'd3: r[31:24] = b;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/x86_instruction_length_decoder_top.sv
// x86 instruction length decoder, top level.
// Byte-serial decode state, result computation and a two-entry result buffer.
// Depends on x86ild_pkg.
//
//   port   direction  handshake                   payload
//   code   in         code_valid / code_stall     code_t: one code byte and its address
//   insn   out        insn_valid / insn_stall     insn_t: one decoded instruction
//
// One code byte is taken every cycle while code_stall is low.
// A byte that ends an instruction writes its request into the result buffer at the
// edge that accepts it; insn_valid is high from the next cycle.
// The result buffer holds two requests; code_stall is high while both entries hold
// a request, including the cycle in which the head leaves.
// Reset clears the decode state to expecting an opcode and empties the buffer.
module x86_instruction_length_decoder_top
	import x86ild_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  code_valid,
	output logic  code_stall,
	input  code_t code,
	output logic  insn_valid,
	input  logic  insn_stall,
	output insn_t insn
);

	typedef enum logic [4:0] {
		PH_OPCODE = 5'b00001,
		PH_MODRM  = 5'b00010,
		PH_SIB    = 5'b00100,
		PH_DISP   = 5'b01000,
		PH_IMM    = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  op_q, op_n;
	logic [7:0]  modrm_q, modrm_n;
	logic [7:0]  sib_q, sib_n;
	logic [31:0] disp_q, disp_n;
	logic [31:0] imm_q, imm_n;
	logic [2:0]  left_q, left_n;
	logic [3:0]  count_q, count_n;
	logic [31:0] addr_q, addr_n;

	logic [7:0]  b;
	opclass_t    cls;
	logic        go_imm, done, unknown, emit;
	logic        take, push, pop;
	insn_t       res;
	insn_t       e0_q, e1_q;
	logic        v0_q, v1_q;

	assign b = code.code_byte;
	assign op_n = (phase_q == PH_OPCODE) ? b : op_q;
	assign cls = classify(op_n);

	always_comb begin
		phase_n = phase_q;
		modrm_n = modrm_q;
		sib_n = sib_q;
		disp_n = disp_q;
		imm_n = imm_q;
		left_n = left_q;
		count_n = count_q + 4'd1;
		addr_n = addr_q;
		go_imm = 1'b0;
		done = 1'b0;
		unknown = 1'b0;
		case (phase_q)
			PH_OPCODE: begin
				modrm_n = '0;
				sib_n = '0;
				disp_n = '0;
				imm_n = '0;
				left_n = '0;
				count_n = 4'd1;
				addr_n = code.instr_address;
				if (!cls.listed) begin
					unknown = 1'b1;
				end else if (cls.modrm) begin
					phase_n = PH_MODRM;
				end else begin
					go_imm = 1'b1;
				end
			end
			PH_MODRM: begin
				modrm_n = b;
				if (b[7:6] == MOD_REG) begin
					go_imm = 1'b1;
				end else if (b[2:0] == RM_SIB) begin
					phase_n = PH_SIB;
				end else if (b[7:6] == MOD_NODISP) begin
					if (b[2:0] == RM_DISP32) begin
						phase_n = PH_DISP;
						left_n = 3'd4;
					end else begin
						go_imm = 1'b1;
					end
				end else begin
					phase_n = PH_DISP;
					left_n = (b[7:6] == MOD_DISP8) ? 3'd1 : 3'd4;
				end
			end
			PH_SIB: begin
				sib_n = b;
				if (modrm_q[7:6] == MOD_NODISP) begin
					if (b[2:0] == RM_DISP32) begin
						phase_n = PH_DISP;
						left_n = 3'd4;
					end else begin
						go_imm = 1'b1;
					end
				end else begin
					phase_n = PH_DISP;
					left_n = (modrm_q[7:6] == MOD_DISP8) ? 3'd1 : 3'd4;
				end
			end
			PH_DISP: begin
				if (modrm_q[7:6] == MOD_DISP8) begin
					disp_n = {{24{b[7]}}, b};
					left_n = '0;
				end else begin
					disp_n = disp_q | place_byte(b, 2'(3'd4 - left_q));
					left_n = left_q - 3'd1;
				end
				if (left_n == 3'd0) begin
					go_imm = 1'b1;
				end
			end
			PH_IMM: begin
				imm_n = imm_q | place_byte(b,
					(cls.kind == K_IMM32) ? 2'(3'd4 - left_q) : 2'(3'd1 - left_q));
				left_n = left_q - 3'd1;
				if (left_n == 3'd0) begin
					done = 1'b1;
				end
			end
			default: phase_n = PH_OPCODE;
		endcase
		if (go_imm) begin
			if (cls.kind == K_NONE) begin
				done = 1'b1;
			end else begin
				phase_n = PH_IMM;
				left_n = (cls.kind == K_IMM32) ? 3'd4 : 3'd1;
			end
		end
		if (done) begin
			phase_n = PH_OPCODE;
		end
	end

	assign emit = unknown | done;

	always_comb begin
		res.status = unknown ? ST_UNKNOWN : (cls.modrm ? ST_MODRM : ST_PLAIN);
		res.opcode = op_n;
		res.length = count_n;
		res.modrm_byte = cls.modrm ? modrm_n : 8'd0;
		res.has_sib = cls.modrm && (modrm_n[7:6] != MOD_REG) && (modrm_n[2:0] == RM_SIB);
		res.sib_byte = res.has_sib ? sib_n : 8'd0;
		res.displacement = disp_n;
		res.immediate = imm_n;
		res.size_class = cls.modrm ? cls.size : SZ_BYTE;
		res.branch_target = (cls.kind == K_REL8)
			? addr_n + 32'(count_n) + {{24{imm_n[7]}}, imm_n[7:0]}
			: 32'd0;
	end

	assign take = code_valid && !code_stall;
	assign push = take && emit;
	assign pop = v0_q && !insn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q <= '0;
			modrm_q <= '0;
			sib_q <= '0;
			disp_q <= '0;
			imm_q <= '0;
			left_q <= '0;
			count_q <= '0;
			addr_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			op_q <= op_n;
			modrm_q <= modrm_n;
			sib_q <= sib_n;
			disp_q <= disp_n;
			imm_q <= imm_n;
			left_q <= left_n;
			count_q <= count_n;
			addr_q <= addr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop) begin
			if (v1_q) begin
				v1_q <= 1'b0;
			end else begin
				v0_q <= push;
			end
		end else if (push) begin
			if (!v0_q) begin
				v0_q <= 1'b1;
			end else begin
				v1_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				e0_q <= e1_q;
			end else if (push) begin
				e0_q <= res;
			end
		end else if (push) begin
			if (!v0_q) begin
				e0_q <= res;
			end else begin
				e1_q <= res;
			end
		end
	end

	assign insn = e0_q;
	assign insn_valid = v0_q;
	assign code_stall = v1_q;

	a_buffer_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("second buffer entry valid without head");

	a_unknown_len: assert property (@(posedge clk) disable iff (!arst_n)
		(insn_valid && insn.status == ST_UNKNOWN) |-> (insn.length == 4'd1))
		else $error("unknown opcode request with length other than one");

	a_phase_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (phase_q == PH_OPCODE))
		else $error("decode did not return to opcode after a request");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		code_stall |-> (insn_valid && v1_q))
		else $error("code stalled while result buffer has room");

endmodule

>>> tb/sv/x86ild_checker.sv
// Checker for the x86 instruction length decoder.
// Watches the code and insn channels, predicts each decoded instruction and compares.
// Depends on x86ild_pkg.
module x86ild_checker
	import x86ild_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_valid,
	input  logic        code_stall,
	input  code_t       code,
	input  logic        insn_valid,
	input  logic        insn_stall,
	input  insn_t       insn,
	output int unsigned mismatches,
	output int unsigned pending
);

	typedef enum logic [2:0] {
		WANT_OPCODE,
		WANT_MODRM,
		WANT_SIB,
		WANT_DISP,
		WANT_IMM
	} decode_phase_t;

	decode_phase_t phase;
	logic [7:0]    opcode_r;
	logic [7:0]    modrm_r;
	logic [7:0]    sib_r;
	logic [31:0]   disp_acc;
	logic [31:0]   imm_acc;
	logic [31:0]   start_addr;
	logic [2:0]    bytes_left;
	logic [3:0]    byte_cnt;
	insn_t         expected_insns[$];
	int unsigned   errs;

	string field_name [10] = '{"status", "opcode", "length", "modrm_byte", "has_sib",
		"sib_byte", "displacement", "immediate", "size_class", "branch_target"};

	function automatic opclass_t op_info(input logic [7:0] op);
		opclass_t c;
		c = '0;
		if (op == OP_ESCAPE) begin
			c = '0;
		end else if (op < 8'h40) begin
			c.listed = 1'b1;
			casez (op[2:0])
				3'b0??: begin
					c.modrm = 1'b1;
					c.size = op[0] ? SZ_DWORD : SZ_BYTE;
				end
				3'b100: c.kind = K_IMM8;
				3'b101: c.kind = K_IMM32;
				default: c.kind = K_NONE;
			endcase
		end else if (op <= 8'h61) begin
			c.listed = 1'b1;
		end else if (op[7:4] == 4'h7) begin
			c.listed = 1'b1;
			c.kind = K_REL8;
		end else begin
			c.listed = 1'b1;
			case (op)
				8'h62: begin c.modrm = 1'b1; c.size = SZ_QWORD; end
				8'h63: begin c.modrm = 1'b1; c.size = SZ_WORD; end
				8'h68: c.kind = K_IMM32;
				8'h69: begin c.modrm = 1'b1; c.size = SZ_DWORD; c.kind = K_IMM32; end
				8'h6A: c.kind = K_IMM8;
				8'h6B: begin c.modrm = 1'b1; c.size = SZ_DWORD; c.kind = K_IMM8; end
				8'h80: begin c.modrm = 1'b1; c.size = SZ_BYTE; c.kind = K_IMM8; end
				8'h81: begin c.modrm = 1'b1; c.size = SZ_DWORD; c.kind = K_IMM32; end
				8'h83: begin c.modrm = 1'b1; c.size = SZ_DWORD; c.kind = K_IMM8; end
				8'h84, 8'h86: begin c.modrm = 1'b1; c.size = SZ_BYTE; end
				8'h85, 8'h87: begin c.modrm = 1'b1; c.size = SZ_DWORD; end
				8'h64, 8'h65, 8'h66, 8'h67, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h82: c.listed = 1'b1;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic [31:0] field_of(input insn_t t, input int idx);
		case (idx)
			0: return 32'(t.status);
			1: return 32'(t.opcode);
			2: return 32'(t.length);
			3: return 32'(t.modrm_byte);
			4: return 32'(t.has_sib);
			5: return 32'(t.sib_byte);
			6: return t.displacement;
			7: return t.immediate;
			8: return 32'(t.size_class);
			default: return t.branch_target;
		endcase
	endfunction

	task automatic push_insn();
		opclass_t c;
		insn_t    t;
		c = op_info(opcode_r);
		t = '0;
		t.status = c.modrm ? ST_MODRM : ST_PLAIN;
		t.opcode = opcode_r;
		t.length = byte_cnt;
		if (c.modrm) begin
			t.modrm_byte = modrm_r;
			t.size_class = c.size;
			if (modrm_r[7:6] != MOD_REG && modrm_r[2:0] == RM_SIB) begin
				t.has_sib = 1'b1;
				t.sib_byte = sib_r;
			end
		end
		t.displacement = disp_acc;
		t.immediate = imm_acc;
		if (c.kind == K_REL8)
			t.branch_target = start_addr + 32'(byte_cnt) + {{24{imm_acc[7]}}, imm_acc[7:0]};
		expected_insns.push_back(t);
		phase = WANT_OPCODE;
	endtask

	task automatic operands_done();
		opclass_t c;
		c = op_info(opcode_r);
		if (c.kind == K_NONE) begin
			push_insn();
		end else begin
			bytes_left = (c.kind == K_IMM32) ? 3'd4 : 3'd1;
			phase = WANT_IMM;
		end
	endtask

	task automatic disp_follows(input logic [1:0] mod);
		bytes_left = (mod == MOD_DISP8) ? 3'd1 : 3'd4;
		phase = WANT_DISP;
	endtask

	task automatic decode_byte(input code_t c);
		logic [7:0] b;
		logic [1:0] mod;
		logic [1:0] pos;
		opclass_t   oc;
		insn_t      t;
		b = c.code_byte;
		mod = modrm_r[7:6];
		if (phase != WANT_OPCODE)
			byte_cnt = byte_cnt + 4'd1;
		case (phase)
			WANT_MODRM: begin
				modrm_r = b;
				mod = b[7:6];
				if (mod == MOD_REG)
					operands_done();
				else if (b[2:0] == RM_SIB)
					phase = WANT_SIB;
				else if (mod == MOD_NODISP && b[2:0] != RM_DISP32)
					operands_done();
				else
					disp_follows(mod);
			end
			WANT_SIB: begin
				sib_r = b;
				if (mod == MOD_NODISP && b[2:0] != RM_DISP32)
					operands_done();
				else
					disp_follows(mod);
			end
			WANT_DISP: begin
				if (mod == MOD_DISP8) begin
					disp_acc = {{24{b[7]}}, b};
					bytes_left = 3'd0;
				end else begin
					pos = 2'(3'd4 - bytes_left);
					disp_acc = disp_acc | (32'(b) << {pos, 3'b000});
					bytes_left = bytes_left - 3'd1;
				end
				if (bytes_left == 3'd0)
					operands_done();
			end
			WANT_IMM: begin
				oc = op_info(opcode_r);
				pos = 2'(((oc.kind == K_IMM32) ? 3'd4 : 3'd1) - bytes_left);
				imm_acc = imm_acc | (32'(b) << {pos, 3'b000});
				bytes_left = bytes_left - 3'd1;
				if (bytes_left == 3'd0)
					push_insn();
			end
			default: begin
				oc = op_info(b);
				opcode_r = b;
				modrm_r = '0;
				sib_r = '0;
				disp_acc = '0;
				imm_acc = '0;
				bytes_left = '0;
				byte_cnt = 4'd1;
				start_addr = c.instr_address;
				phase = WANT_OPCODE;
				if (!oc.listed) begin
					t = '0;
					t.status = ST_UNKNOWN;
					t.opcode = b;
					t.length = 4'd1;
					expected_insns.push_back(t);
				end else if (oc.modrm) begin
					phase = WANT_MODRM;
				end else begin
					operands_done();
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		insn_t want;
		if (!arst_n) begin
			phase = WANT_OPCODE;
			opcode_r = '0;
			modrm_r = '0;
			sib_r = '0;
			disp_acc = '0;
			imm_acc = '0;
			start_addr = '0;
			bytes_left = '0;
			byte_cnt = '0;
			expected_insns.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (insn_valid && !insn_stall) begin
				if (expected_insns.size() == 0) begin
					errs++;
					$display("%0t: unexpected request, expected none, actual %h", $time, insn);
				end else begin
					want = expected_insns.pop_front();
					for (int i = 0; i < 10; i++) begin
						if (field_of(want, i) !== field_of(insn, i)) begin
							errs++;
							$display("%0t: %s expected %h actual %h", $time, field_name[i],
								field_of(want, i), field_of(insn, i));
						end
					end
				end
			end
			if (code_valid && !code_stall)
				decode_byte(code);
			pending <= expected_insns.size();
			mismatches <= errs;
		end
	end

endmodule

>>> tb/sv/tb_x86_instruction_length_decoder_top.sv
// Testbench top for the x86 instruction length decoder.
// Drives directed and random code streams under several idle and stall mixes.
// Depends on x86ild_pkg, x86ild_checker and x86_instruction_length_decoder_top.
module tb_x86_instruction_length_decoder_top;
	import x86ild_pkg::*;

	localparam int BYTES_PER_PHASE = 485;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        code_valid = 1'b0;
	code_t       code = '0;
	logic        insn_stall = 1'b0;
	logic        code_stall;
	logic        insn_valid;
	insn_t       insn;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_sent = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [7:0]  seq[$];

	always #1 clk = ~clk;

	x86_instruction_length_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.insn_valid (insn_valid),
		.insn_stall (insn_stall),
		.insn       (insn)
	);

	x86ild_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.insn_valid (insn_valid),
		.insn_stall (insn_stall),
		.insn       (insn),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk)
		insn_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if ((code_valid && !code_stall) || (insn_valid && !insn_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code <= '{code_byte: b, instr_address: addr};
		@(posedge clk);
		while (code_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_seq(input logic [31:0] addr);
		foreach (seq[i])
			send_byte(seq[i], (i == 0) ? addr : $urandom());
	endtask

	function automatic logic [31:0] pick_address();
		if ($urandom_range(9) == 0)
			return 32'hFFFF_FFF8 + 32'($urandom_range(7));
		return $urandom();
	endfunction

	// mostly well-formed instructions with random content, some raw bytes
	task automatic build_random_insn();
		opclass_t   oc;
		logic [7:0] op;
		logic [7:0] modrm;
		logic [7:0] sib;
		int         n_disp;
		int         n_imm;
		int         pick;
		seq.delete();
		pick = $urandom_range(99);
		if (pick < 10) begin
			seq.push_back(8'($urandom_range(255)));
			return;
		end
		if (pick < 13)
			op = OP_ESCAPE;
		else if (pick < 17)
			op = 8'($urandom_range(8'hFF, 8'h88));
		else
			op = 8'($urandom_range(8'h87));
		seq.push_back(op);
		oc = classify(op);
		n_disp = 0;
		if (oc.modrm) begin
			modrm = 8'($urandom_range(255));
			case ($urandom_range(3))
				0: modrm[2:0] = RM_SIB;
				1: modrm[2:0] = RM_DISP32;
				default: ;
			endcase
			seq.push_back(modrm);
			if (modrm[7:6] == MOD_DISP8)
				n_disp = 1;
			else if (modrm[7:6] != MOD_NODISP && modrm[7:6] != MOD_REG)
				n_disp = 4;
			else if (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_DISP32)
				n_disp = 4;
			if (modrm[7:6] != MOD_REG && modrm[2:0] == RM_SIB) begin
				sib = 8'($urandom_range(255));
				if ($urandom_range(2) == 0)
					sib[2:0] = RM_DISP32;
				seq.push_back(sib);
				if (modrm[7:6] == MOD_NODISP)
					n_disp = (sib[2:0] == RM_DISP32) ? 4 : 0;
			end
		end
		n_imm = (oc.kind == K_NONE) ? 0 : (oc.kind == K_IMM32) ? 4 : 1;
		repeat (n_disp + n_imm)
			seq.push_back(8'($urandom_range(255)));
	endtask

	initial begin
		int target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		seq = '{OP_ESCAPE};
		send_seq(32'h0000_0000);
		seq = '{8'hFF};
		send_seq(32'hFFFF_FFFF);
		seq = '{8'h82};
		send_seq($urandom());
		seq = '{8'h63, 8'hC0};
		send_seq($urandom());
		seq = '{8'h00, 8'h05, 8'h78, 8'h56, 8'h34, 8'h12};
		send_seq($urandom());
		seq = '{8'h01, 8'h04, 8'h25, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_seq($urandom());
		seq = '{8'h80, 8'h44, 8'h00, 8'h80, 8'hFF};
		send_seq($urandom());
		seq = '{8'h74, 8'h80};
		send_seq(32'hFFFF_FFFF);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 57; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 57; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			target = bytes_sent + BYTES_PER_PHASE;
			while (bytes_sent < target) begin
				build_random_insn();
				send_seq(pick_address());
			end
			// hold until every pending request has drained
			code_valid <= 1'b0;
			@(posedge clk);
			while (pending != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
